// ===== hdl/dlmtf_pkg.sv =====
// Shared types and constants for the move-to-front log table.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dlmtf_pkg;

  localparam int TableDepth = 64;
  localparam int IDX_W = $clog2(TableDepth);
  localparam int FILL_W = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    CMD_LOG   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_MERGED   = 3'd1,
    ST_READ_OK  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MISS,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_READ_RD,
    S_READ_OUT
  } state_t;

  // One table line, kept in recency order in the entry memory
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [2:0]  hook;
    logic [2:0]  verdict;
    logic [7:0]  cause;
    logic [31:0] seen;
    logic [31:0] count;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_scan;
    logic step;
    logic settle_hit;
    logic settle_miss;
    logic rd_shift;
    logic wr_shift;
    logic wr_front;
    logic rd_index;
    logic clear;
    logic emit_log;
    logic emit_read;
    logic emit_clear;
    logic emit_bad;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_zero;
    logic match;
    logic last;
    logic idx_zero;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/dlmtf_ctrl.sv =====
// Sequencer for the log table: scan, move-to-front shift, read and clear steps.
// Depends on dlmtf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dlmtf_ctrl
  import dlmtf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic [1:0] in_cmd,
  input  dp_stat_t      stat,
  output ctl_cmd_t      cmd,
  output logic          busy
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_cmd)
            CMD_LOG: begin
              cmd.capture = 1'b1;
              state_nxt   = stat.fill_zero ? S_MISS : S_SCAN_RD;
            end
            CMD_READ: begin
              cmd.capture = 1'b1;
              state_nxt   = S_READ_RD;
            end
            CMD_CLEAR: begin
              cmd.clear      = 1'b1;
              cmd.emit_clear = 1'b1;
            end
            default: cmd.emit_bad = 1'b1;
          endcase
        end
      end
      S_MISS: begin
        cmd.settle_miss = 1'b1;
        state_nxt       = S_SHIFT_RD;
      end
      S_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        priority if (stat.match) begin
          cmd.settle_hit = 1'b1;
          state_nxt      = S_SHIFT_RD;
        end else if (stat.last) begin
          cmd.settle_miss = 1'b1;
          state_nxt       = S_SHIFT_RD;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat.idx_zero) begin
          cmd.wr_front = 1'b1;
          cmd.emit_log = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.rd_shift = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_READ_RD: begin
        cmd.rd_index = 1'b1;
        state_nxt    = S_READ_OUT;
      end
      S_READ_OUT: begin
        cmd.emit_read = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // Checks
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_log, cmd.emit_read, cmd.emit_clear, cmd.emit_bad}))
    else $error("more than one result in a cycle");
  a_front_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_front |=> state_r == S_IDLE)
    else $error("front write did not end the item");
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !cmd.wr_shift && !cmd.wr_front)
    else $error("table write while idle");

endmodule
`default_nettype wire

// ===== hdl/dlmtf_dp.sv =====
// Datapath: entry memory in recency order, fill count, index and result registers.
// Depends on dlmtf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dlmtf_dp
  import dlmtf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  ctl_cmd_t         cmd,
  output dp_stat_t         stat,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [31:0] in_dst_addr,
  input  wire logic [15:0] in_src_port_in,
  input  wire logic [15:0] in_dst_port_in,
  input  wire logic [7:0]  in_proto_in,
  input  wire logic [2:0]  in_hook_in,
  input  wire logic [2:0]  in_verdict_in,
  input  wire logic [7:0]  in_cause_in,
  input  wire logic [31:0] in_event_time,
  input  wire logic [5:0]  in_read_index,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [6:0]       out_occupancy,
  output logic [31:0]      out_time,
  output logic [31:0]      out_src_addr,
  output logic [31:0]      out_dst_addr,
  output logic [15:0]      out_src_port,
  output logic [15:0]      out_dst_port,
  output logic [7:0]       out_proto,
  output logic [2:0]       out_hook,
  output logic [2:0]       out_verdict,
  output logic [7:0]       out_cause,
  output logic [31:0]      out_hits
);

  entry_t             mem [TableDepth];
  entry_t             rdata_r;
  entry_t             key_r;
  entry_t             new_r, new_nxt;
  logic [5:0]         ridx_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic               hit_r;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               wr_en;
  logic               read_ok;

  // Read and write addresses
  always_comb begin
    priority if (cmd.rd_shift) rd_addr = idx_r - IDX_W'(1);
    else if (cmd.rd_index)     rd_addr = IDX_W'(ridx_r);
    else if (cmd.rd_scan)      rd_addr = idx_r;
    else                       rd_addr = idx_r;
    wr_en   = cmd.wr_shift | cmd.wr_front;
    wr_addr = cmd.wr_front ? '0 : idx_r;
    wr_data = cmd.wr_front ? new_r : rdata_r;
  end

  // Entry memory
  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Status back to the controller
  assign stat.fill_zero = (fill_r == '0);
  assign stat.match = (rdata_r.src_addr == key_r.src_addr) &&
                      (rdata_r.dst_addr == key_r.dst_addr) &&
                      (rdata_r.sport == key_r.sport) &&
                      (rdata_r.dport == key_r.dport) &&
                      (rdata_r.proto == key_r.proto) && (rdata_r.hook == key_r.hook) &&
                      (rdata_r.verdict == key_r.verdict) && (rdata_r.cause == key_r.cause);
  assign stat.last = ({1'b0, idx_r} + FILL_W'(1)) == fill_r;
  assign stat.idx_zero = (idx_r == '0);
  assign read_ok = (FILL_W'(ridx_r) < fill_r);

  // Index, fill count and pending entry
  always_comb begin
    idx_nxt  = idx_r;
    fill_nxt = fill_r;
    new_nxt  = new_r;
    if (cmd.capture) begin
      idx_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt = idx_r + IDX_W'(1);
    end else if (cmd.wr_shift) begin
      idx_nxt = idx_r - IDX_W'(1);
    end else if (cmd.settle_hit) begin
      new_nxt       = rdata_r;
      new_nxt.seen  = key_r.seen;
      new_nxt.count = (rdata_r.count == 32'hFFFF_FFFF) ? rdata_r.count
                                                       : rdata_r.count + 32'd1;
    end else if (cmd.settle_miss) begin
      new_nxt       = key_r;
      new_nxt.count = 32'd1;
      if (fill_r < FILL_W'(TableDepth)) begin
        idx_nxt  = IDX_W'(fill_r);
        fill_nxt = fill_r + FILL_W'(1);
      end else begin
        idx_nxt = IDX_W'(TableDepth - 1);
      end
    end else if (cmd.clear) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fill_r <= '0;
    else        fill_r <= fill_nxt;
    idx_r <= idx_nxt;
    new_r <= new_nxt;
    if (cmd.settle_hit) hit_r <= 1'b1;
    else if (cmd.settle_miss) hit_r <= 1'b0;
    if (cmd.capture) begin
      key_r.src_addr <= in_src_addr;
      key_r.dst_addr <= in_dst_addr;
      key_r.sport    <= in_src_port_in;
      key_r.dport    <= in_dst_port_in;
      key_r.proto    <= in_proto_in;
      key_r.hook     <= in_hook_in;
      key_r.verdict  <= in_verdict_in;
      key_r.cause    <= in_cause_in;
      key_r.seen     <= in_event_time;
      key_r.count    <= '0;
      ridx_r         <= in_read_index;
    end
  end

  // Result registers
  logic    any_emit;
  status_t status_nxt;
  logic [31:0] hits_nxt;
  entry_t  shown_nxt;
  assign any_emit = cmd.emit_log | cmd.emit_read | cmd.emit_clear | cmd.emit_bad;

  // Result fields; entry fields stay zero except on a valid read
  always_comb begin
    status_nxt = ST_EMPTY;
    hits_nxt   = '0;
    shown_nxt  = '0;
    if (cmd.emit_log) begin
      status_nxt = hit_r ? ST_MERGED : ST_INSERTED;
      hits_nxt   = new_r.count;
    end else if (cmd.emit_read && read_ok) begin
      status_nxt = ST_READ_OK;
      shown_nxt  = rdata_r;
      hits_nxt   = rdata_r.count;
    end else if (cmd.emit_clear) begin
      status_nxt = ST_CLEARED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= any_emit;
    if (any_emit) begin
      out_occupancy <= 7'(fill_nxt);
      out_status    <= status_nxt;
      out_time      <= shown_nxt.seen;
      out_src_addr  <= shown_nxt.src_addr;
      out_dst_addr  <= shown_nxt.dst_addr;
      out_src_port  <= shown_nxt.sport;
      out_dst_port  <= shown_nxt.dport;
      out_proto     <= shown_nxt.proto;
      out_hook      <= shown_nxt.hook;
      out_verdict   <= shown_nxt.verdict;
      out_cause     <= shown_nxt.cause;
      out_hits      <= hits_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dedup_log_table_move_to_front_core.sv =====
// Top level of the move-to-front de-duplicating log table.
// Depends on dlmtf_pkg, dlmtf_ctrl and dlmtf_dp.
//
// Usage:
//   Input: drive in_* and raise start; the transfer happens at an edge with
//   start high and busy low. in_cmd selects log event, read or clear; any
//   other code gives an empty-status result and changes nothing.
//   Result: one per item, on out_* for one cycle with out_valid high. The
//   receiver cannot stall; the result must be taken that cycle.
//   Timing: clear and unused codes answer one cycle after the transfer.
//   A read fetches the addressed entry and then issues it. A log event scans
//   stored entries one at a time up to the match (or all of them on a miss;
//   none on an empty table), then moves the entry to the front one position
//   at a time through the single entry memory read port, and writes it
//   there. busy stays high until the result is issued.
//   Reset (rst_n low, synchronous) empties the table and idles the
//   sequencer; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module dedup_log_table_move_to_front_core
  import dlmtf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [31:0] in_dst_addr,
  input  wire logic [15:0] in_src_port_in,
  input  wire logic [15:0] in_dst_port_in,
  input  wire logic [7:0]  in_proto_in,
  input  wire logic [2:0]  in_hook_in,
  input  wire logic [2:0]  in_verdict_in,
  input  wire logic [7:0]  in_cause_in,
  input  wire logic [31:0] in_event_time,
  input  wire logic [5:0]  in_read_index,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [6:0]       out_occupancy,
  output logic [31:0]      out_time,
  output logic [31:0]      out_src_addr,
  output logic [31:0]      out_dst_addr,
  output logic [15:0]      out_src_port,
  output logic [15:0]      out_dst_port,
  output logic [7:0]       out_proto,
  output logic [2:0]       out_hook,
  output logic [2:0]       out_verdict,
  output logic [7:0]       out_cause,
  output logic [31:0]      out_hits
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  dlmtf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  dlmtf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_src_addr    (in_src_addr),
    .in_dst_addr    (in_dst_addr),
    .in_src_port_in (in_src_port_in),
    .in_dst_port_in (in_dst_port_in),
    .in_proto_in    (in_proto_in),
    .in_hook_in     (in_hook_in),
    .in_verdict_in  (in_verdict_in),
    .in_cause_in    (in_cause_in),
    .in_event_time  (in_event_time),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_occupancy  (out_occupancy),
    .out_time       (out_time),
    .out_src_addr   (out_src_addr),
    .out_dst_addr   (out_dst_addr),
    .out_src_port   (out_src_port),
    .out_dst_port   (out_dst_port),
    .out_proto      (out_proto),
    .out_hook       (out_hook),
    .out_verdict    (out_verdict),
    .out_cause      (out_cause),
    .out_hits       (out_hits)
  );

endmodule
`default_nettype wire
